[rtl/ket_pkg.sv]
// ----------------------------------------------------------------------------
// ket_pkg
// Shared codes and types for the keyed entry table: opcodes, status codes,
// controller states, cell commands and the scan token flags.
// ----------------------------------------------------------------------------
`default_nettype none

package ket_pkg;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_GET    = 3'd2;
    localparam logic [2:0] OP_UPDATE = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [2:0] STATUS_OK      = 3'd0;
    localparam logic [2:0] STATUS_FULL    = 3'd1;
    localparam logic [2:0] STATUS_DUP     = 3'd2;
    localparam logic [2:0] STATUS_MISSING = 3'd3;
    localparam logic [2:0] STATUS_COLLIDE = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } ket_state_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_WRITE,
        CMD_SHIFT
    } ket_cmd_op_t;

    // Flags that ride along with the scan token from cell to cell.
    typedef struct packed {
        logic valid;
        logic hit_key;
        logic hit_new_key;
    } ket_flags_t;

endpackage

`default_nettype wire

[rtl/ket_cell.sv]
// ----------------------------------------------------------------------------
// ket_cell
// One table slot: holds a key and a value, checks the passing scan token
// against the broadcast keys and hands the token on; takes writes and
// shift-down moves from its upper neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module ket_cell
    import ket_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int DEPTH      = 32,
    parameter int VALUE_BITS = 64
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire [$clog2(DEPTH+1)-1:0] fill_count,
    input  wire [31:0]              q_key,
    input  wire [31:0]              q_new_key,
    input  ket_flags_t              tok_in_flags,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] tok_in_idx,
    input  wire [VALUE_BITS-1:0]    tok_in_val,
    output ket_flags_t              tok_out_flags,
    output wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] tok_out_idx,
    output wire [VALUE_BITS-1:0]    tok_out_val,
    input  ket_cmd_op_t             cmd_op,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] cmd_idx,
    input  wire [31:0]              cmd_key,
    input  wire [VALUE_BITS-1:0]    cmd_val,
    input  wire [31:0]              nbr_key,
    input  wire [VALUE_BITS-1:0]    nbr_val,
    output wire [31:0]              key_out,
    output wire [VALUE_BITS-1:0]    val_out
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] MY_IDX = IW'(IDX);
    localparam logic [CW-1:0] MY_POS = CW'(IDX);

    logic [31:0]           key_reg,  key_next;
    logic [VALUE_BITS-1:0] val_reg,  val_next;
    ket_flags_t            flags_reg, flags_next;
    logic [IW-1:0]         idx_reg,  idx_next;
    logic [VALUE_BITS-1:0] hval_reg, hval_next;

    logic occupied;
    logic hit_k;
    logic hit_n;

    assign occupied = (MY_POS < fill_count);
    assign hit_k    = tok_in_flags.valid && occupied && (key_reg == q_key);
    assign hit_n    = tok_in_flags.valid && occupied && (key_reg == q_new_key);

    always_comb begin
        flags_next.valid       = tok_in_flags.valid;
        flags_next.hit_key     = tok_in_flags.hit_key | hit_k;
        flags_next.hit_new_key = tok_in_flags.hit_new_key | hit_n;
        idx_next  = hit_k ? MY_IDX  : tok_in_idx;
        hval_next = hit_k ? val_reg : tok_in_val;
    end

    always_comb begin
        key_next = key_reg;
        val_next = val_reg;
        case (cmd_op)
            CMD_WRITE: begin
                if (cmd_idx == MY_IDX) begin
                    key_next = cmd_key;
                    val_next = cmd_val;
                end
            end
            CMD_SHIFT: begin
                if (MY_IDX >= cmd_idx) begin
                    key_next = nbr_key;
                    val_next = nbr_val;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        val_reg  <= val_next;
        idx_reg  <= idx_next;
        hval_reg <= hval_next;
    end

    assign tok_out_flags = flags_reg;
    assign tok_out_idx   = idx_reg;
    assign tok_out_val   = hval_reg;
    assign key_out       = key_reg;
    assign val_out       = val_reg;

endmodule

`default_nettype wire

[rtl/keyed_entry_table_top.sv]
// ----------------------------------------------------------------------------
// keyed_entry_table_top
// Bounded table of unique 32-bit keys with add, delete, get, update and
// clear, built as a row of slot cells scanned by a traveling token.
// ----------------------------------------------------------------------------
// One item is in work at a time. An item passes through these steps from
// its input transfer to the point where the next one can be taken, with the
// result register free: launch of the scan token, the token's walk along
// the row of TABLE_DEPTH cells (one cell per cycle, each comparing its
// stored key against key and new_key), capture of the token, and commit of
// the table change with the load of the result. A stalled result transfer
// holds the block in its commit step. Entries stay packed in slots below
// the entry count in insertion order; delete moves all later entries down
// one slot at once, in the commit step. The capacity register may be
// written only while no item is in work; values above TABLE_DEPTH act as
// TABLE_DEPTH. The stores have no reset; only filled slots are read.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_entry_table_top
    import ket_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int VALUE_BITS  = 64
) (
    input  wire         aclk,
    input  wire         aresetn,
    // capacity_limit register
    input  wire         cfg_we,
    input  wire [5:0]   cfg_wdata,
    // input items: opcode[2:0], key[34:3], new_key[66:35], value_data[130:67]
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [135:0] s_tdata,
    // results: status[2:0], found_value[66:3], entry_count[72:67]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [79:0] m_tdata
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int LW = (CW > 6) ? CW : 6;
    localparam logic [LW-1:0] DEPTH_L = LW'(TABLE_DEPTH);

    // Control and item registers
    ket_state_t state_reg, state_next;
    logic            start_reg;
    logic [5:0]      cap_reg;
    logic [CW-1:0]   fill_reg, fill_next;
    logic [2:0]      op_reg;
    logic [31:0]     key_reg;
    logic [31:0]     nkey_reg;
    logic [VALUE_BITS-1:0] val_reg;

    // Captured scan outcome
    ket_flags_t            res_flags_reg;
    logic [IW-1:0]         res_idx_reg;
    logic [VALUE_BITS-1:0] res_val_reg;

    // Result register
    logic        m_valid_reg;
    logic [2:0]  m_status_reg;
    logic [63:0] m_found_reg;
    logic [5:0]  m_count_reg;

    logic s_xfer;
    logic out_free;
    logic commit;

    logic [2:0]            status_c;
    logic [63:0]           found_c;
    ket_cmd_op_t           cmd_op;
    logic [IW-1:0]         cmd_idx;
    logic [31:0]           cmd_key;
    logic [VALUE_BITS-1:0] cmd_val;
    logic [LW-1:0]         cap_ext;
    logic [LW-1:0]         limit;
    logic                  is_full;
    logic                  collide;

    // Token chain and neighbor data
    ket_flags_t            tok_flags [TABLE_DEPTH+1];
    logic [IW-1:0]         tok_idx   [TABLE_DEPTH+1];
    logic [VALUE_BITS-1:0] tok_val   [TABLE_DEPTH+1];
    logic [31:0]           cell_key  [TABLE_DEPTH];
    logic [VALUE_BITS-1:0] cell_val  [TABLE_DEPTH];

    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Token enters cell 0 in the cycle after the input transfer.
    always_comb begin
        tok_flags[0].valid       = start_reg;
        tok_flags[0].hit_key     = 1'b0;
        tok_flags[0].hit_new_key = 1'b0;
        tok_idx[0] = '0;
        tok_val[0] = '0;
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        logic [31:0]           nbr_key;
        logic [VALUE_BITS-1:0] nbr_val;
        // top slot has no upper neighbor; what it takes on delete lies
        // above the new count and is never read
        if (i == TABLE_DEPTH - 1) begin : g_top
            assign nbr_key = cell_key[i];
            assign nbr_val = cell_val[i];
        end else begin : g_mid
            assign nbr_key = cell_key[i+1];
            assign nbr_val = cell_val[i+1];
        end

        ket_cell #(
            .IDX        (i),
            .DEPTH      (TABLE_DEPTH),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .fill_count    (fill_reg),
            .q_key         (key_reg),
            .q_new_key     (nkey_reg),
            .tok_in_flags  (tok_flags[i]),
            .tok_in_idx    (tok_idx[i]),
            .tok_in_val    (tok_val[i]),
            .tok_out_flags (tok_flags[i+1]),
            .tok_out_idx   (tok_idx[i+1]),
            .tok_out_val   (tok_val[i+1]),
            .cmd_op        (cmd_op),
            .cmd_idx       (cmd_idx),
            .cmd_key       (cmd_key),
            .cmd_val       (cmd_val),
            .nbr_key       (nbr_key),
            .nbr_val       (nbr_val),
            .key_out       (cell_key[i]),
            .val_out       (cell_val[i])
        );
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (tok_flags[TABLE_DEPTH].valid) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the controller
    always_comb begin
        s_tready = 1'b0;
        commit   = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_DONE: commit   = out_free;
            default: begin
            end
        endcase
    end

    // Decision from the captured scan. Keys are unique, so a new_key hit is
    // another entry exactly when new_key differs from key.
    assign cap_ext = LW'(cap_reg);
    assign limit   = (cap_ext > DEPTH_L) ? DEPTH_L : cap_ext;
    assign is_full = (LW'(fill_reg) >= limit);
    assign collide = res_flags_reg.hit_new_key && (nkey_reg != key_reg);

    always_comb begin
        status_c  = STATUS_OK;
        found_c   = '0;
        fill_next = fill_reg;
        cmd_op    = CMD_NONE;
        cmd_idx   = res_idx_reg;
        cmd_key   = key_reg;
        cmd_val   = val_reg;
        case (op_reg)
            OP_ADD: begin
                if (is_full) begin
                    status_c = STATUS_FULL;
                end else if (res_flags_reg.hit_key) begin
                    status_c = STATUS_DUP;
                end else begin
                    cmd_op    = CMD_WRITE;
                    cmd_idx   = IW'(fill_reg);
                    fill_next = fill_reg + CW'(1);
                end
            end
            OP_DELETE: begin
                if (!res_flags_reg.hit_key) begin
                    status_c = STATUS_MISSING;
                end else begin
                    cmd_op    = CMD_SHIFT;
                    fill_next = fill_reg - CW'(1);
                end
            end
            OP_GET: begin
                if (!res_flags_reg.hit_key) begin
                    status_c = STATUS_MISSING;
                end else begin
                    found_c = 64'(res_val_reg);
                end
            end
            OP_UPDATE: begin
                if (collide) begin
                    status_c = STATUS_COLLIDE;
                end else if (!res_flags_reg.hit_key) begin
                    status_c = STATUS_MISSING;
                end else begin
                    cmd_op  = CMD_WRITE;
                    cmd_key = nkey_reg;
                end
            end
            OP_CLEAR: begin
                fill_next = '0;
            end
            default: begin
            end
        endcase
        // table changes only on the commit cycle
        if (!commit) begin
            cmd_op    = CMD_NONE;
            fill_next = fill_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            start_reg   <= 1'b0;
            cap_reg     <= 6'd32;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= s_xfer;
            fill_reg  <= fill_next;
            if (cfg_we) cap_reg <= cfg_wdata;
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            op_reg   <= s_tdata[2:0];
            key_reg  <= s_tdata[34:3];
            nkey_reg <= s_tdata[66:35];
            val_reg  <= s_tdata[67 +: VALUE_BITS];
        end
        if (state_reg == ST_SCAN && tok_flags[TABLE_DEPTH].valid) begin
            res_flags_reg <= tok_flags[TABLE_DEPTH];
            res_idx_reg   <= tok_idx[TABLE_DEPTH];
            res_val_reg   <= tok_val[TABLE_DEPTH];
        end
        if (commit) begin
            m_status_reg <= status_c;
            m_found_reg  <= found_c;
            m_count_reg  <= 6'(fill_next);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_count_reg, m_found_reg, m_status_reg};

endmodule

`default_nettype wire

[rtl/ket_checker.sv]
// ----------------------------------------------------------------------------
// ket_checker
// Port-level checks for the keyed entry table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ket_checker
    import ket_pkg::*;
(
    input wire         aclk,
    input wire         aresetn,
    input wire         s_tvalid,
    input wire         s_tready,
    input wire         m_tvalid,
    input wire         m_tready,
    input wire [79:0]  m_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] == STATUS_OK) || (m_tdata[2:0] == STATUS_FULL)
            || (m_tdata[2:0] == STATUS_DUP) || (m_tdata[2:0] == STATUS_MISSING)
            || (m_tdata[2:0] == STATUS_COLLIDE))
        else $error("status code out of range");

    a_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] != STATUS_OK) |-> (m_tdata[66:3] == 64'd0))
        else $error("payload on failed operation");

endmodule

bind keyed_entry_table_top ket_checker u_ket_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[dv/keyed_entry_table_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyed_entry_table_top_test
// Self-checking bench for the keyed entry table. A directed table covers
// empty-table misses, extreme keys and payloads, duplicates, update
// collisions, delete shifting, spare opcodes and capacity limits. It is
// followed by random phases at several capacities, with keys mostly drawn
// from the live table and a small key pool. Every reply is checked against
// an in-bench table model, with random gaps on input and random result
// back-pressure.
// ----------------------------------------------------------------------------

module keyed_entry_table_top_test;
    import ket_pkg::*;

    localparam int DEPTH        = 32;
    localparam int KEY_POOL     = 40;
    localparam int DRAIN_CYCLES = 40;       // > one item's scan and commit
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int PHASES       = 6;

    // opcodes outside the defined set: no-ops that still answer
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    localparam logic [31:0] KEY_MIN  = 32'h8000_0000;
    localparam logic [31:0] KEY_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] KEY_ONES = 32'hFFFF_FFFF;
    localparam logic [63:0] VAL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] found;
        logic [5:0]  count;
    } reply_t;

    typedef enum logic {ROW_ITEM, ROW_CAPACITY} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [2:0]  op;
        logic [31:0] key;
        logic [31:0] new_key;
        logic [63:0] value;     // capacity in [5:0] for ROW_CAPACITY
        logic        fixed;     // reply typed in below
        reply_t      want;
    } plan_row_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [5:0]   cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;    // opcode, key, new_key, value_data, 5'b0 pad
    logic         m_tvalid;
    logic         m_tready;
    logic [79:0]  m_tdata;    // status, found_value, entry_count, zero pad

    keyed_entry_table_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // ------------------------------------------------------------------
    // Table model: packed slots in insertion order, linear key search
    // ------------------------------------------------------------------
    logic [31:0] key_tab [0:DEPTH-1];
    logic [63:0] val_tab [0:DEPTH-1];
    logic [5:0]  fill;
    logic [5:0]  capacity;

    logic [31:0] key_pool [0:KEY_POOL-1];
    reply_t      table_replies [$];      // replies owed by the block, oldest first
    plan_row_t   plan [$];
    int          mismatch_count;
    int          cycle_count;
    int          source_quiet;
    int          sink_quiet;

    // slot of k, or DEPTH on a miss
    function automatic int slot_of(input logic [31:0] k);
        for (int i = 0; i < fill; i++) begin
            if (key_tab[i] == k) return i;
        end
        return DEPTH;
    endfunction

    function automatic reply_t apply_table_op(input logic [2:0] op, input logic [31:0] k,
                                              input logic [31:0] nk, input logic [63:0] v);
        reply_t r;
        int     slot;
        int     clash;
        int     limit;
        r = '0;
        r.status = STATUS_OK;
        limit = (capacity > DEPTH) ? DEPTH : capacity;
        case (op)
            OP_ADD: begin
                // full wins over duplicate
                if (fill >= limit) begin
                    r.status = STATUS_FULL;
                end else if (slot_of(k) < DEPTH) begin
                    r.status = STATUS_DUP;
                end else begin
                    key_tab[fill[4:0]] = k;
                    val_tab[fill[4:0]] = v;
                    fill++;
                end
            end
            OP_DELETE: begin
                slot = slot_of(k);
                if (slot >= DEPTH) begin
                    r.status = STATUS_MISSING;
                end else begin
                    for (int j = slot; j + 1 < fill; j++) begin
                        key_tab[j] = key_tab[j+1];
                        val_tab[j] = val_tab[j+1];
                    end
                    fill--;
                end
            end
            OP_GET: begin
                slot = slot_of(k);
                if (slot >= DEPTH) r.status = STATUS_MISSING;
                else               r.found = val_tab[slot];
            end
            OP_UPDATE: begin
                // a clash with some other entry beats a missing key
                slot  = slot_of(k);
                clash = DEPTH;
                for (int j = 0; j < fill; j++) begin
                    if (j != slot && key_tab[j] == nk) begin
                        clash = j;
                        break;
                    end
                end
                if (clash < DEPTH) begin
                    r.status = STATUS_COLLIDE;
                end else if (slot >= DEPTH) begin
                    r.status = STATUS_MISSING;
                end else begin
                    key_tab[slot] = nk;
                    val_tab[slot] = v;
                end
            end
            OP_CLEAR: fill = '0;
            default: ;
        endcase
        r.count = fill;
        return r;
    endfunction

    // mostly live keys for lookups, else the pool, now and then anything
    function automatic logic [31:0] pick_key(input bit live_first);
        if (live_first && fill != 0 && $urandom_range(0, 9) < 7)
            return key_tab[$urandom_range(0, fill - 1)];
        if ($urandom_range(0, 9) < 9)
            return key_pool[$urandom_range(0, KEY_POOL - 1)];
        return $urandom;
    endfunction

    // per-transfer wait, with stretches of back-to-back traffic
    task automatic draw_wait(inout int quiet, output int n);
        if (quiet > 0) begin
            quiet--;
            n = 0;
        end else begin
            n = $urandom_range(0, 11);
            if ($urandom_range(0, 15) == 0) quiet = $urandom_range(5, 30);
        end
    endtask

    task automatic plan_row(input row_kind_t kind, input logic [2:0] op,
                            input logic [31:0] k, input logic [31:0] nk,
                            input logic [63:0] v, input logic fixed,
                            input logic [2:0] st, input logic [63:0] found,
                            input logic [5:0] cnt);
        plan_row_t row;
        row.kind = kind;
        row.op = op;
        row.key = k;
        row.new_key = nk;
        row.value = v;
        row.fixed = fixed;
        row.want.status = st;
        row.want.found = found;
        row.want.count = cnt;
        plan.push_back(row);
    endtask

    // One input transfer. The model runs on acceptance; a typed reply, when
    // given, replaces the predicted one in the queue. Valid stays high into
    // the next call when no gap is drawn; callers that stop sending lower it.
    task automatic send_item(input logic [2:0] op, input logic [31:0] k,
                             input logic [31:0] nk, input logic [63:0] v,
                             input logic fixed, input reply_t want);
        reply_t predicted;
        int     gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, v, nk, k, op};
        do @(posedge aclk); while (!s_tready);
        predicted = apply_table_op(op, k, nk, v);
        table_replies.push_back(fixed ? want : predicted);
        draw_wait(source_quiet, gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // capacity changes only with the block idle: input closed, replies in
    task automatic write_capacity(input logic [5:0] cap);
        s_tvalid <= 1'b0;
        while (table_replies.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wdata <= cap;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we   <= 1'b0;
        capacity = cap;
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, watchdog
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d replies outstanding", $time,
                     table_replies.size());
            $display("keyed_entry_table_top regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: random back-pressure. Either tready is raised ahead of
    // the result, or the result is left waiting before tready goes up.
    // ------------------------------------------------------------------
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            draw_wait(sink_quiet, stall);
            if (sink_quiet == 0 && $urandom_range(0, 1) == 1) begin
                m_tready <= 1'b0;
                do @(posedge aclk); while (!m_tvalid);
                repeat (stall) @(posedge aclk);
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // compare each result transfer with the oldest owed reply
    always @(posedge aclk) begin
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (table_replies.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                mismatch_count++;
            end else begin
                want = table_replies.pop_front();
                check_field("status", 64'(want.status), 64'(m_tdata[2:0]));
                check_field("found_value", want.found, m_tdata[66:3]);
                check_field("entry_count", 64'(want.count), 64'(m_tdata[72:67]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int          phase_cap [PHASES];
        int          phase_len [PHASES];
        int          roll;
        logic [2:0]  op;
        logic [31:0] k;
        logic [31:0] nk;

        phase_cap = '{32, 63, 6, 0, 1, 20};
        phase_len = '{120, 100, 50, 15, 25, 90};

        mismatch_count = 0;
        cycle_count    = 0;
        source_quiet   = 0;
        sink_quiet     = 0;
        fill           = '0;
        capacity       = 6'd32;     // reset value of the register
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;

        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = '0;
        key_pool[3] = KEY_ONES;
        for (int i = 4; i < KEY_POOL; i++) key_pool[i] = $urandom;

        // empty table, extreme keys and payloads, duplicates
        plan_row(ROW_ITEM, OP_GET,    32'd5,   '0, '0, 1'b1, STATUS_MISSING, '0, 6'd0);
        plan_row(ROW_ITEM, OP_DELETE, 32'd5,   '0, '0, 1'b1, STATUS_MISSING, '0, 6'd0);
        plan_row(ROW_ITEM, OP_UPDATE, 32'd5, 32'd6, '0, 1'b1, STATUS_MISSING, '0, 6'd0);
        plan_row(ROW_ITEM, OP_ADD,    KEY_MIN, '0, VAL_ONES, 1'b1, STATUS_OK, '0, 6'd1);
        plan_row(ROW_ITEM, OP_ADD,    KEY_MAX, '0, '0, 1'b1, STATUS_OK, '0, 6'd2);
        plan_row(ROW_ITEM, OP_ADD,    KEY_MIN, '0, {16{4'h5}}, 1'b1, STATUS_DUP, '0, 6'd2);
        plan_row(ROW_ITEM, OP_GET,    KEY_MIN, '0, '0, 1'b1, STATUS_OK, VAL_ONES, 6'd2);
        plan_row(ROW_ITEM, OP_GET,    KEY_MAX, '0, '0, 1'b1, STATUS_OK, '0, 6'd2);
        plan_row(ROW_ITEM, OP_ADD,    '0, '0, 64'h0123_4567_89AB_CDEF, 1'b1, STATUS_OK, '0,
                 6'd3);
        plan_row(ROW_ITEM, OP_ADD,    KEY_ONES, '0, {16{4'hA}}, 1'b1, STATUS_OK, '0, 6'd4);
        // update: rename to itself, clash with another entry (even with key
        // absent), plain miss, real rename
        plan_row(ROW_ITEM, OP_UPDATE, '0, '0, 64'hFEDC_BA98_7654_3210, 1'b1, STATUS_OK, '0,
                 6'd4);
        plan_row(ROW_ITEM, OP_GET,    '0, '0, '0, 1'b0, '0, '0, '0);
        plan_row(ROW_ITEM, OP_UPDATE, '0, KEY_MAX, '0, 1'b1, STATUS_COLLIDE, '0, 6'd4);
        plan_row(ROW_ITEM, OP_UPDATE, 32'd12345, KEY_MIN, '0, 1'b1, STATUS_COLLIDE, '0, 6'd4);
        plan_row(ROW_ITEM, OP_UPDATE, 32'd12345, 32'd777, '0, 1'b1, STATUS_MISSING, '0, 6'd4);
        plan_row(ROW_ITEM, OP_UPDATE, KEY_ONES, 32'd42, {16{4'h1}}, 1'b0, '0, '0, '0);
        // delete from the front shifts everything down; then the tail
        plan_row(ROW_ITEM, OP_DELETE, KEY_MIN, '0, '0, 1'b0, '0, '0, '0);
        plan_row(ROW_ITEM, OP_GET,    32'd42, '0, '0, 1'b0, '0, '0, '0);
        plan_row(ROW_ITEM, OP_DELETE, 32'd42, '0, '0, 1'b0, '0, '0, '0);
        plan_row(ROW_ITEM, OP_SPARE_FIRST, KEY_MAX, '0, VAL_ONES, 1'b0, '0, '0, '0);
        plan_row(ROW_ITEM, OP_SPARE_LAST,  KEY_MAX, '0, VAL_ONES, 1'b0, '0, '0, '0);
        // capacity at the fill level: full is reported ahead of duplicate
        plan_row(ROW_CAPACITY, '0, '0, '0, 64'd2, 1'b0, '0, '0, '0);
        plan_row(ROW_ITEM, OP_ADD,    32'd9,   '0, '0, 1'b1, STATUS_FULL, '0, 6'd2);
        plan_row(ROW_ITEM, OP_ADD,    KEY_MAX, '0, '0, 1'b1, STATUS_FULL, '0, 6'd2);
        // zero capacity
        plan_row(ROW_CAPACITY, '0, '0, '0, 64'd0, 1'b0, '0, '0, '0);
        plan_row(ROW_ITEM, OP_CLEAR,  '0, '0, '0, 1'b1, STATUS_OK, '0, 6'd0);
        plan_row(ROW_ITEM, OP_ADD,    32'd1, '0, '0, 1'b1, STATUS_FULL, '0, 6'd0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CAPACITY)
                write_capacity(plan[i].value[5:0]);
            else
                send_item(plan[i].op, plan[i].key, plan[i].new_key, plan[i].value,
                          plan[i].fixed, plan[i].want);
        end

        // random phases, each at its own capacity (63 acts as full depth)
        for (int p = 0; p < PHASES; p++) begin
            write_capacity(6'(phase_cap[p]));
            repeat (phase_len[p]) begin
                roll = $urandom_range(0, 63);
                if      (roll < 29) op = OP_ADD;
                else if (roll < 38) op = OP_DELETE;
                else if (roll < 48) op = OP_GET;
                else if (roll < 60) op = OP_UPDATE;
                else if (roll < 61) op = OP_CLEAR;
                else                op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
                k = pick_key(op != OP_ADD);
                case ($urandom_range(0, 3))
                    0:       nk = k;
                    1:       nk = $urandom;
                    default: nk = pick_key(1'b0);
                endcase
                send_item(op, k, nk, {$urandom, $urandom}, 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        while (table_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("keyed_entry_table_top regression: pass");
        end else begin
            $display("keyed_entry_table_top regression: fail");
        end
        $finish;
    end

endmodule
